// File: rtl/mwcr_pkg.sv
// Shared types and constants for the max-weight connected region core.
package mwcr_pkg;

  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_VALUE_BITS = 16;

  localparam int CFG_W   = 7;
  localparam int SUM_W   = 28;
  localparam int APB_W   = 32;
  localparam int PADDR_W = 3;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;
  localparam logic [SUM_W-1:0] SUM_MAX       = '1;

  typedef enum logic {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP,
    ST_CELL_ADDR,
    ST_CELL_RD,
    ST_CELL_ADD,
    ST_NB_ADDR,
    ST_NB_RD,
    ST_NB_TEST
  } state_t;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_LEFT,
    DIR_DOWN,
    DIR_UP
  } dir_t;

  function automatic dir_t next_dir(input dir_t d);
    dir_t n;
    unique case (d)
      DIR_RIGHT: n = DIR_LEFT;
      DIR_LEFT:  n = DIR_DOWN;
      DIR_DOWN:  n = DIR_UP;
      DIR_UP:    n = DIR_RIGHT;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/max_weight_connected_region_core.sv
// Top level of the max-weight connected region core.
//
// Cells arrive in raster order, one item per cycle while busy is low. The
// item that completes grid_rows * grid_cols cells, each size clamped into
// 1..MAX, starts the flood fill, and busy stays high until done pulses for
// one cycle with best_region_sum. The receiver cannot stall: take the result
// in that cycle. The fill works through the grid one access at a time, since
// every access goes through one read port of the cell and visited memories
// and one shared multiply-add address unit. After reset, busy stays high
// while all MAX_ROWS * MAX_COLS entries of the visited map are cleared;
// configuration writes are taken during that pass.
module max_weight_connected_region_core
  import mwcr_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] cell_value,
  output logic                  done,
  output logic [SUM_W-1:0]      best_region_sum,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_W-1:0]      pwdata,
  output logic [APB_W-1:0]      prdata,
  output logic                  pready
);

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int ADD_W  = ((SUM_W > VALUE_BITS) ? SUM_W : VALUE_BITS) + 1;
  localparam int STK_W  = ROW_W + COL_W;

  logic [CFG_W-1:0] grid_rows;
  logic [CFG_W-1:0] grid_cols;

  state_t state;
  state_t state_next;
  dir_t   dir;

  logic [CNT_W-1:0]  load_count;
  logic [IDX_W-1:0]  clr;
  logic [IDX_W-1:0]  scan_idx;
  logic [ROW_W-1:0]  scan_r;
  logic [COL_W-1:0]  scan_c;
  logic [ROW_W-1:0]  cur_r;
  logic [COL_W-1:0]  cur_c;
  logic [ROW_W-1:0]  nb_r;
  logic [COL_W-1:0]  nb_c;
  logic [CNT_W-1:0]  sp;
  logic [CNT_W-1:0]  mul_q;
  logic [SUM_W-1:0]  region_sum;
  logic [SUM_W-1:0]  best_sum;

  logic [VALUE_BITS-1:0] cell_mem [CELLS];
  logic                  vis_mem  [CELLS];
  logic [STK_W-1:0]      stack_mem[CELLS];
  logic [VALUE_BITS-1:0] cell_q;
  logic                  vis_q;
  logic [STK_W-1:0]      stk_q;

  logic [RCNT_W-1:0] rows_eff;
  logic [CCNT_W-1:0] cols_eff;
  logic [RCNT_W-1:0] mul_a;
  logic [COL_W-1:0]  mul_c;
  logic [CNT_W-1:0]  mul_y;

  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  stk_rd_addr;
  logic              vis_we;
  logic [IDX_W-1:0]  vis_waddr;
  logic              vis_wdata;
  logic              stk_we;
  logic [IDX_W-1:0]  stk_waddr;
  logic [STK_W-1:0]  stk_wdata;

  logic              accept;
  logic              load_last;
  logic              cfg_we;
  logic              scan_last;
  logic              live_cell;
  logic              push;
  logic              nb_ok;
  logic [ROW_W-1:0]  nb_r_next;
  logic [COL_W-1:0]  nb_c_next;
  logic [ADD_W-1:0]  sum_ext;
  logic [SUM_W-1:0]  region_sum_next;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= CFG_DIM_RESET;
      grid_cols <= CFG_DIM_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_GRID_ROWS: grid_rows <= pwdata[CFG_W-1:0];
        REG_GRID_COLS: grid_cols <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[2]))
      REG_GRID_ROWS: prdata = APB_W'(grid_rows);
      REG_GRID_COLS: prdata = APB_W'(grid_cols);
    endcase
  end

  // Clamp the sizes into 1..MAX
  always_comb begin
    priority if (grid_rows == '0) begin
      rows_eff = RCNT_W'(1);
    end else if (32'(grid_rows) > MAX_ROWS) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = RCNT_W'(grid_rows);
    end
    priority if (grid_cols == '0) begin
      cols_eff = CCNT_W'(1);
    end else if (32'(grid_cols) > MAX_COLS) begin
      cols_eff = CCNT_W'(MAX_COLS);
    end else begin
      cols_eff = CCNT_W'(grid_cols);
    end
  end

  // Shared multiply-add: a * cols + c
  assign mul_y = CNT_W'(CNT_W'(mul_a) * CNT_W'(cols_eff)) + CNT_W'(mul_c);

  assign accept    = start && !busy;
  assign load_last = (load_count + CNT_W'(1)) >= mul_y;
  assign scan_last = (RCNT_W'(scan_r) + RCNT_W'(1) == rows_eff) &&
                     (CCNT_W'(scan_c) + CCNT_W'(1) == cols_eff);
  assign live_cell = !vis_q && (cell_q != '0);
  assign push      = live_cell && (sp != CNT_W'(CELLS));

  assign sum_ext = ADD_W'(region_sum) + ADD_W'(cell_q);
  assign region_sum_next = (sum_ext > ADD_W'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];

  always_comb begin
    nb_ok     = 1'b0;
    nb_r_next = cur_r;
    nb_c_next = cur_c;
    unique case (dir)
      DIR_RIGHT: begin
        nb_ok     = (CCNT_W'(cur_c) + CCNT_W'(1)) < cols_eff;
        nb_c_next = cur_c + COL_W'(1);
      end
      DIR_LEFT: begin
        nb_ok     = cur_c != '0;
        nb_c_next = cur_c - COL_W'(1);
      end
      DIR_DOWN: begin
        nb_ok     = (RCNT_W'(cur_r) + RCNT_W'(1)) < rows_eff;
        nb_r_next = cur_r + ROW_W'(1);
      end
      DIR_UP: begin
        nb_ok     = cur_r != '0;
        nb_r_next = cur_r - ROW_W'(1);
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr == IDX_W'(CELLS - 1)) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (accept && load_last) state_next = ST_SCAN_RD;
      end
      ST_SCAN_RD: state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        priority if (live_cell) begin
          state_next = ST_POP;
        end else if (scan_last) begin
          state_next = ST_LOAD;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_POP:       state_next = ST_CELL_ADDR;
      ST_CELL_ADDR: state_next = ST_CELL_RD;
      ST_CELL_RD:   state_next = ST_CELL_ADD;
      ST_CELL_ADD:  state_next = ST_NB_ADDR;
      ST_NB_ADDR: begin
        priority if (nb_ok) begin
          state_next = ST_NB_RD;
        end else if (dir == DIR_UP) begin
          state_next = (sp != '0) ? ST_POP : ST_SCAN_RD;
        end else begin
          state_next = ST_NB_ADDR;
        end
      end
      ST_NB_RD: state_next = ST_NB_TEST;
      ST_NB_TEST: begin
        priority if (dir != DIR_UP) begin
          state_next = ST_NB_ADDR;
        end else if (push || sp != '0) begin
          state_next = ST_POP;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    busy        = state != ST_LOAD;
    mul_a       = '0;
    mul_c       = '0;
    rd_addr     = scan_idx;
    stk_rd_addr = IDX_W'(sp - CNT_W'(1));
    vis_we      = 1'b0;
    vis_waddr   = scan_idx;
    vis_wdata   = 1'b0;
    stk_we      = 1'b0;
    stk_waddr   = sp[IDX_W-1:0];
    stk_wdata   = {nb_r, nb_c};
    unique case (state)
      ST_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr;
      end
      ST_LOAD: begin
        mul_a = rows_eff;
      end
      ST_SCAN_CHK: begin
        vis_we    = 1'b1;
        vis_wdata = live_cell;
        stk_we    = live_cell;
        stk_waddr = '0;
        stk_wdata = {scan_r, scan_c};
      end
      ST_CELL_ADDR: begin
        mul_a = RCNT_W'(stk_q[STK_W-1:COL_W]);
        mul_c = stk_q[COL_W-1:0];
      end
      ST_CELL_RD, ST_NB_RD: begin
        rd_addr = mul_q[IDX_W-1:0];
      end
      ST_NB_ADDR: begin
        mul_a = RCNT_W'(nb_r_next);
        mul_c = nb_c_next;
      end
      ST_NB_TEST: begin
        vis_we    = push;
        vis_waddr = mul_q[IDX_W-1:0];
        vis_wdata = 1'b1;
        stk_we    = push;
      end
      default: begin
      end
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (accept) cell_mem[load_count[IDX_W-1:0]] <= cell_value;
    cell_q <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    vis_q <= vis_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    stk_q <= stack_mem[stk_rd_addr];
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr        <= '0;
      load_count <= '0;
      sp         <= '0;
      region_sum <= '0;
      best_sum   <= '0;
      dir        <= DIR_RIGHT;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + IDX_W'(1);
        end
        ST_LOAD: begin
          if (accept) begin
            if (load_last) begin
              load_count <= '0;
              best_sum   <= '0;
              scan_idx   <= '0;
              scan_r     <= '0;
              scan_c     <= '0;
            end else begin
              load_count <= load_count + CNT_W'(1);
            end
          end
        end
        ST_SCAN_CHK: begin
          priority if (live_cell) begin
            sp         <= CNT_W'(1);
            region_sum <= '0;
          end else if (scan_last) begin
            done            <= 1'b1;
            best_region_sum <= best_sum;
            best_sum        <= '0;
            region_sum      <= '0;
            sp              <= '0;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
            if (CCNT_W'(scan_c) + CCNT_W'(1) == cols_eff) begin
              scan_c <= '0;
              scan_r <= scan_r + ROW_W'(1);
            end else begin
              scan_c <= scan_c + COL_W'(1);
            end
          end
        end
        ST_POP: begin
          sp <= sp - CNT_W'(1);
        end
        ST_CELL_ADDR: begin
          mul_q <= mul_y;
          cur_r <= stk_q[STK_W-1:COL_W];
          cur_c <= stk_q[COL_W-1:0];
        end
        ST_CELL_ADD: begin
          region_sum <= region_sum_next;
          if (region_sum_next > best_sum) best_sum <= region_sum_next;
          dir <= DIR_RIGHT;
        end
        ST_NB_ADDR: begin
          if (nb_ok) begin
            mul_q <= mul_y;
            nb_r  <= nb_r_next;
            nb_c  <= nb_c_next;
          end else begin
            dir <= next_dir(dir);
          end
        end
        ST_NB_TEST: begin
          if (push) sp <= sp + CNT_W'(1);
          dir <= next_dir(dir);
        end
        default: begin
        end
      endcase
    end
  end

endmodule
